// File: design/shell_exchange_sort_with_counts_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shell exchange sort block
// Shared concurrent check forms used by the block's modules.
// ----------------------------------------------------------------------------
`ifndef SHELL_EXCHANGE_SORT_WITH_COUNTS_DEFINES_SVH
`define SHELL_EXCHANGE_SORT_WITH_COUNTS_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SESC_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SESC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sesc_pkg.sv
// ----------------------------------------------------------------------------
// Shell exchange sort package
// Payload types, counter control group and constants shared by the block.
// ----------------------------------------------------------------------------
package sesc_pkg;

    localparam int DEFAULT_MAX_ITEMS = 16;
    localparam int VALUE_W           = 32;
    localparam int COUNT_W           = 16;
    localparam int MOVES_PER_SWAP    = 3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      end_of_list;
        logic        [COUNT_W-1:0] comparisons;
        logic        [COUNT_W-1:0] swaps;
        logic        [COUNT_W-1:0] moves;
    } result_t;

    typedef struct packed {
        logic clear;
        logic compare;
        logic exchange;
    } cnt_ctl_t;

    typedef struct packed {
        logic [COUNT_W-1:0] comparisons;
        logic [COUNT_W-1:0] swaps;
        logic [COUNT_W-1:0] moves;
    } cnt_val_t;

endpackage

// File: design/sesc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sesc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: design/sesc_counters.sv
// ----------------------------------------------------------------------------
// Sort statistics counters
// Saturating comparison, exchange and move totals for one sorted list.
// ----------------------------------------------------------------------------
`include "shell_exchange_sort_with_counts_defines.svh"

module sesc_counters (
    input  logic              clk,
    input  logic              rst_n,
    input  sesc_pkg::cnt_ctl_t ctl,
    output sesc_pkg::cnt_val_t counts
);

    localparam logic [sesc_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    logic [sesc_pkg::COUNT_W-1:0] cmp_reg;
    logic [sesc_pkg::COUNT_W-1:0] swap_reg;
    logic [sesc_pkg::COUNT_W-1:0] move_reg;
    logic [sesc_pkg::COUNT_W:0]   cmp_sum;
    logic [sesc_pkg::COUNT_W:0]   swap_sum;
    logic [sesc_pkg::COUNT_W:0]   move_sum;

    assign cmp_sum  = {1'b0, cmp_reg} + 1'b1;
    assign swap_sum = {1'b0, swap_reg} + 1'b1;
    assign move_sum = {1'b0, move_reg} + (sesc_pkg::COUNT_W+1)'(sesc_pkg::MOVES_PER_SWAP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_reg  <= '0;
            swap_reg <= '0;
            move_reg <= '0;
        end
        else if (ctl.clear)
        begin
            cmp_reg  <= '0;
            swap_reg <= '0;
            move_reg <= '0;
        end
        else
        begin
            if (ctl.compare)
            begin
                cmp_reg <= cmp_sum[sesc_pkg::COUNT_W] ? COUNT_MAX
                                                      : cmp_sum[sesc_pkg::COUNT_W-1:0];
            end
            if (ctl.exchange)
            begin
                swap_reg <= swap_sum[sesc_pkg::COUNT_W] ? COUNT_MAX
                                                        : swap_sum[sesc_pkg::COUNT_W-1:0];
                move_reg <= move_sum[sesc_pkg::COUNT_W] ? COUNT_MAX
                                                        : move_sum[sesc_pkg::COUNT_W-1:0];
            end
        end
    end

    assign counts.comparisons = cmp_reg;
    assign counts.swaps       = swap_reg;
    assign counts.moves       = move_reg;

    `SESC_CHECK_NOW(a_moves_cover_swaps, 1'b1, move_reg >= swap_reg, "move total below swap total")
    `SESC_CHECK_NOW(a_cmp_cover_swaps, 1'b1, cmp_reg >= swap_reg, "swap total above comparison total")

endmodule

// File: design/shell_exchange_sort_with_counts.sv
// ----------------------------------------------------------------------------
// Shell exchange sort with operation counts
// Loads a list of signed values, sorts it with a gap-halving exchange sort
// and streams the sorted list out with comparison, swap and move totals.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle until a transaction with last set; up to
// MAX_ITEMS are kept and further ones are dropped. The block then stops taking
// input and sorts in place in a single RAM with one read and one write port:
// each comparison passes the step, read and compare states, an exchange adds
// a swap state, and each pass and gap adds a step or gap state, so the sort
// time grows roughly with the square of the list length. The sorted list then
// leaves one result at a time, each held until taken, all carrying the same
// final totals. After the last result is taken the next list is accepted.
`include "shell_exchange_sort_with_counts_defines.svh"

module shell_exchange_sort_with_counts #(
    parameter int MAX_ITEMS = sesc_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sesc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output sesc_pkg::result_t result
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_GAP,
        S_STEP,
        S_READ_B,
        S_CMP,
        S_SWAP,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } state_t;

    state_t                          state_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                gap_reg;
    logic [IDX_W-1:0]                i_reg;
    logic [IDX_W-1:0]                k_reg;
    logic                            swapped_reg;
    logic signed [sesc_pkg::VALUE_W-1:0] a_reg;
    logic                            result_valid_reg;
    sesc_pkg::result_t               result_reg;

    logic [CNT_W:0]                  pair_sum;
    logic [IDX_W-1:0]                j_idx;
    logic                            pair_in_range;
    logic                            greater;
    logic                            accept;
    logic                            last_taken;
    logic                            reload_ok;

    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [sesc_pkg::VALUE_W-1:0]    wr_data;
    logic [IDX_W-1:0]                rd_addr;
    logic [sesc_pkg::VALUE_W-1:0]    rd_data;

    sesc_pkg::cnt_ctl_t              cnt_ctl;
    sesc_pkg::cnt_val_t              counts;

    assign item_ready    = (state_reg == S_LOAD);
    assign accept        = item_valid && item_ready;
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;
    assign pair_sum      = (CNT_W+1)'(i_reg) + (CNT_W+1)'(gap_reg);
    assign j_idx         = pair_sum[IDX_W-1:0];
    assign pair_in_range = (pair_sum < (CNT_W+1)'(count_reg));
    assign greater       = (a_reg > $signed(rd_data));
    assign last_taken    = result_valid && result_ready && result.end_of_list;
    assign reload_ok     = item_ready && (count_reg == '0);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = i_reg;
        wr_data = rd_data;
        rd_addr = k_reg;
        case (state_reg)
            S_LOAD:
            begin
                wr_en   = accept && (count_reg < CNT_W'(MAX_ITEMS));
                wr_addr = count_reg[IDX_W-1:0];
                wr_data = item.value;
            end
            S_STEP:
            begin
                rd_addr = i_reg;
            end
            S_READ_B:
            begin
                rd_addr = j_idx;
            end
            S_CMP:
            begin
                wr_en   = greater;
                wr_addr = i_reg;
                wr_data = rd_data;
            end
            S_SWAP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_idx;
                wr_data = a_reg;
            end
            default:
            begin
                rd_addr = k_reg;
            end
        endcase
    end

    assign cnt_ctl.clear    = (state_reg == S_INIT);
    assign cnt_ctl.compare  = (state_reg == S_CMP);
    assign cnt_ctl.exchange = (state_reg == S_CMP) && greater;

    sesc_ram #(
        .WIDTH (sesc_pkg::VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sesc_counters u_counters (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (cnt_ctl),
        .counts (counts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            gap_reg          <= '0;
            i_reg            <= '0;
            k_reg            <= '0;
            swapped_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            a_reg            <= '0;
            result_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (count_reg < CNT_W'(MAX_ITEMS))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (item.last)
                        begin
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    gap_reg   <= count_reg;
                    state_reg <= S_GAP;
                end
                S_GAP:
                begin
                    if (gap_reg > CNT_W'(1))
                    begin
                        gap_reg     <= gap_reg >> 1;
                        i_reg       <= '0;
                        swapped_reg <= 1'b0;
                        state_reg   <= S_STEP;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                end
                S_STEP:
                begin
                    if (pair_in_range)
                    begin
                        state_reg <= S_READ_B;
                    end
                    else if (swapped_reg)
                    begin
                        i_reg       <= '0;
                        swapped_reg <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= S_GAP;
                    end
                end
                S_READ_B:
                begin
                    a_reg     <= $signed(rd_data);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (greater)
                    begin
                        swapped_reg <= 1'b1;
                        state_reg   <= S_SWAP;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_STEP;
                    end
                end
                S_SWAP:
                begin
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_STEP;
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    result_reg.sorted_value <= $signed(rd_data);
                    result_reg.end_of_list  <= ((CNT_W'(k_reg) + 1'b1) == count_reg);
                    result_reg.comparisons  <= counts.comparisons;
                    result_reg.swaps        <= counts.swaps;
                    result_reg.moves        <= counts.moves;
                    result_valid_reg        <= 1'b1;
                    state_reg               <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT:
                begin
                    if (result_ready)
                    begin
                        result_valid_reg <= 1'b0;
                        if (result_reg.end_of_list)
                        begin
                            count_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    `SESC_CHECK_NOW(a_no_overlap, item_ready, !result_valid, "result pending while input open")
    `SESC_CHECK_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ITEMS), "count above depth")
    `SESC_CHECK_NEXT(a_reload_after_end, last_taken, reload_ok, "not ready for the next list")

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the shell exchange sort block
// Sends lists of signed values with random gaps. Each accepted list is sorted
// in the testbench with the same gap-halving exchange scheme. Every result
// transaction is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITEMS     = sesc_pkg::DEFAULT_MAX_ITEMS;
    localparam int VALUE_W       = sesc_pkg::VALUE_W;
    localparam int COUNT_W       = sesc_pkg::COUNT_W;
    localparam int TARGET_ITEMS  = 420;
    localparam int MAX_WAIT      = 19;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 100;

    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_EXTREME,
        FILL_DESCENDING
    } fill_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    sesc_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    sesc_pkg::result_t result;

    sesc_pkg::item_t   pending_items[$];
    sesc_pkg::result_t expected_results[$];

    logic signed [VALUE_W-1:0] list_buf [MAX_ITEMS];
    int      list_len = 0;

    int      items_total = 0;
    int      items_accepted = 0;
    int      lists_done = 0;
    int      error_count = 0;

    logic    item_took = 1'b0;
    logic    result_took = 1'b0;

    int      send_wait = 0;
    bit      send_quiet = 1'b0;
    int      recv_wait = 0;
    bit      recv_quiet = 1'b0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;

    shell_exchange_sort_with_counts u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] total,
                                                  input int inc);
        logic [COUNT_W:0] sum;
        sum = {1'b0, total} + (COUNT_W+1)'(inc);
        return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
    endfunction

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic absorb_item(input sesc_pkg::item_t it);
        logic signed [VALUE_W-1:0] tmp;
        logic [COUNT_W-1:0] n_cmp;
        logic [COUNT_W-1:0] n_swap;
        logic [COUNT_W-1:0] n_move;
        int      gap_now;
        bit      swapped;
        sesc_pkg::result_t r;
        if (list_len < MAX_ITEMS)
        begin
            list_buf[list_len] = it.value;
            list_len++;
        end
        if (it.last)
        begin
            n_cmp   = '0;
            n_swap  = '0;
            n_move  = '0;
            gap_now = list_len;
            while (gap_now > 1)
            begin
                gap_now = gap_now / 2;
                swapped = 1'b1;
                while (swapped)
                begin
                    swapped = 1'b0;
                    for (int i = 0; i + gap_now < list_len; i++)
                    begin
                        n_cmp = sat_add(n_cmp, 1);
                        if (list_buf[i] > list_buf[i + gap_now])
                        begin
                            tmp                    = list_buf[i];
                            list_buf[i]            = list_buf[i + gap_now];
                            list_buf[i + gap_now]  = tmp;
                            n_swap                 = sat_add(n_swap, 1);
                            n_move                 = sat_add(n_move,
                                                             sesc_pkg::MOVES_PER_SWAP);
                            swapped                = 1'b1;
                        end
                    end
                end
            end
            for (int k = 0; k < list_len; k++)
            begin
                r.sorted_value = list_buf[k];
                r.end_of_list  = (k == list_len - 1);
                r.comparisons  = n_cmp;
                r.swaps        = n_swap;
                r.moves        = n_move;
                expected_results.push_back(r);
            end
            list_len = 0;
        end
    endtask

    task automatic check_result(input sesc_pkg::result_t got);
        sesc_pkg::result_t exp;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result transaction: sorted_value %0d", got.sorted_value);
            error_count++;
        end
        else
        begin
            exp = expected_results.pop_front();
            if (got.sorted_value !== exp.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d", exp.sorted_value,
                       got.sorted_value);
                error_count++;
            end
            if (got.end_of_list !== exp.end_of_list)
            begin
                $error("end_of_list: expected %0d, got %0d", exp.end_of_list,
                       got.end_of_list);
                error_count++;
            end
            if (got.comparisons !== exp.comparisons)
            begin
                $error("comparisons: expected %0d, got %0d", exp.comparisons,
                       got.comparisons);
                error_count++;
            end
            if (got.swaps !== exp.swaps)
            begin
                $error("swaps: expected %0d, got %0d", exp.swaps, got.swaps);
                error_count++;
            end
            if (got.moves !== exp.moves)
            begin
                $error("moves: expected %0d, got %0d", exp.moves, got.moves);
                error_count++;
            end
        end
    endtask

    task automatic push_item(input logic signed [VALUE_W-1:0] value, input logic last);
        sesc_pkg::item_t t;
        t.value = value;
        t.last  = last;
        pending_items.push_back(t);
        items_total++;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(input fill_t f, input int k,
                                                            input int len);
        case (f)
            FILL_NARROW:
                return $urandom_range(0, 8) - 4;
            FILL_EXTREME:
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            FILL_DESCENDING:
                return (len - k) * 1000 - 9000 + $urandom_range(0, 3);
            default:
                return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        item_took   <= rst_n && item_valid && item_ready;
        result_took <= rst_n && result_valid && result_ready;
        if (rst_n && item_valid && item_ready)
        begin
            absorb_item(item);
            items_accepted <= items_accepted + 1;
        end
        if (rst_n && result_valid && result_ready)
        begin
            check_result(result);
            if (result.end_of_list)
            begin
                lists_done <= lists_done + 1;
            end
        end
    end

    always @(negedge clk)
    begin
        logic next_valid;
        if (rst_n && !(item_valid && !item_took))
        begin
            if (item_valid)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    send_quiet = ~send_quiet;
                end
                send_wait = draw_wait(send_quiet);
            end
            if (send_wait > 0)
            begin
                send_wait--;
                next_valid = 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item <= pending_items.pop_front();
                next_valid = 1'b1;
            end
            else
            begin
                next_valid = 1'b0;
            end
            item_valid <= next_valid;
        end
    end

    always @(negedge clk)
    begin
        logic next_ready;
        if (rst_n)
        begin
            if (!hold_done && lists_done == 2 && result_valid)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                if (result_took)
                begin
                    if ($urandom_range(0, 39) == 0)
                    begin
                        recv_quiet = ~recv_quiet;
                    end
                    recv_wait = draw_wait(recv_quiet);
                end
                if (recv_wait > 0)
                begin
                    recv_wait--;
                    next_ready = 1'b0;
                end
                else
                begin
                    next_ready = 1'b1;
                end
            end
            result_ready <= next_ready;
        end
    end

    initial
    begin
        int    kept;
        int    len;
        fill_t fill;

        push_item(32'sd12345, 1'b1);

        push_item(32'h7FFF_FFFF, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h0000_0001, 1'b1);

        for (int k = 0; k < MAX_ITEMS + 2; k++)
        begin
            push_item(900 - k * 50, k == MAX_ITEMS + 1);
        end

        kept = 0;
        while (kept < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
            end
            else
            begin
                len = $urandom_range(1, MAX_ITEMS);
            end
            fill = fill_t'($urandom_range(0, 3));
            for (int k = 0; k < len; k++)
            begin
                push_item(pick_value(fill, k, len), k == len - 1);
            end
            kept += (len > MAX_ITEMS) ? MAX_ITEMS : len;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(negedge clk);
        end
        while (!(items_accepted == items_total && expected_results.size() == 0));
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
